// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the hotplug governor.
// Needs a clock named clk and an active-high reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CCG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define CCG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/ccg_pkg.sv =====
// Shared constants and types of the core-count hotplug governor.
// No dependencies; every other file but assert_macros.svh imports this package.
package ccg_pkg;

  localparam int CORE_COUNT    = 4;
  localparam int HISTORY_DEPTH = 10;
  localparam int FRACTION_BITS = 11;

  localparam int FUNC_W    = 2;
  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(CORE_COUNT + 1);
  localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
  localparam int SUM_W     = $clog2(HISTORY_DEPTH * SAMPLE_MAX + 1);
  // load levels carry one spare bit for avg + half
  localparam int LVL_W     = SAMPLE_W + 1;

  // Sum / HISTORY_DEPTH as multiply by a rounded-up reciprocal; exact for
  // every SUM_W-bit sum.
  localparam int DIV_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((longint'(1) << DIV_SHIFT) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);

  localparam int FIX_HALF   = 2 ** (FRACTION_BITS - 1);
  localparam int ALMOST_TWO = (2 << FRACTION_BITS) - 1;
  localparam int SEED       = (ALMOST_TWO > SAMPLE_MAX) ? SAMPLE_MAX : ALMOST_TWO;
  localparam int SEED_SUM   = SEED * HISTORY_DEPTH;

  localparam int DELAY_RESET = 12000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SUSPEND = 2'd1,
    FUNC_RESUME  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 2'd0,
    CFG_CORE_FLOOR   = 2'd1,
    CFG_CORE_CEILING = 2'd2,
    CFG_VERIFY_DELAY = 2'd3
  } cfg_idx_t;

  // Result of the target pick: updated moving sum and clamped core count.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] target;
  } pick_t;

  typedef struct packed {
    logic [CORE_COUNT-1:0] up;
    logic [CORE_COUNT-1:0] down;
    logic                  fault;
  } masks_t;

endpackage

// ===== hdl/ccg_ifs.sv =====
// Valid/ready channel interfaces of the hotplug governor: events, results, config.
// Depends on ccg_pkg.
interface ccg_event_if import ccg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [SAMPLE_W-1:0]   load_sample;
  logic [CORE_COUNT-1:0] online_mask;

  modport source(output valid, func, load_sample, online_mask, input ready);
  modport sink(input valid, func, load_sample, online_mask, output ready);
endinterface

interface ccg_result_if import ccg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CORE_COUNT-1:0] cores_up_mask;
  logic [CORE_COUNT-1:0] cores_down_mask;
  logic [CNT_W-1:0]      desired_cores;
  logic [CNT_W-1:0]      online_count;
  logic                  verify_pending;

  modport source(output valid, cores_up_mask, cores_down_mask, desired_cores,
                 online_count, verify_pending, input ready);
  modport sink(input valid, cores_up_mask, cores_down_mask, desired_cores,
               online_count, verify_pending, output ready);
endinterface

interface ccg_cfg_if import ccg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DELAY_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ccg_pick.sv =====
// Moving-sum update, average, hysteresis and clamping of the target core count.
// Depends on ccg_pkg.
module ccg_pick import ccg_pkg::*; (
  input  logic [SUM_W-1:0]    load_sum,
  input  logic [SAMPLE_W-1:0] old_entry,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [CNT_W-1:0]    believed,
  input  logic [CNT_W-1:0]    core_floor,
  input  logic [CNT_W-1:0]    core_ceiling,
  output pick_t               pick
);

  logic [SUM_W-1:0]    sum_new;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quot;
  logic [LVL_W-1:0]    avg;
  logic [LVL_W-1:0]    up_n;
  logic [LVL_W-1:0]    down_n;
  logic [LVL_W-1:0]    tgt_hyst;
  logic [LVL_W-1:0]    tgt;
  logic [LVL_W-1:0]    believed_w;
  logic [LVL_W-1:0]    min_w;
  logic [LVL_W-1:0]    max_w;

  assign sum_new    = load_sum - SUM_W'(old_entry) + SUM_W'(sample);
  assign prod       = PROD_W'(sum_new) * PROD_W'(RECIP);
  assign quot       = prod >> DIV_SHIFT;
  assign avg        = LVL_W'(quot[SAMPLE_W-1:0]);
  assign believed_w = LVL_W'(believed);
  assign min_w      = LVL_W'(core_floor);
  assign max_w      = LVL_W'(core_ceiling);

  // up threshold sits half a core above, down threshold half a core below
  assign up_n   = (avg > LVL_W'(FIX_HALF)) ? ((avg - LVL_W'(FIX_HALF)) >> FRACTION_BITS)
                                           : LVL_W'(1);
  assign down_n = (avg + LVL_W'(FIX_HALF)) >> FRACTION_BITS;

  always_comb begin
    priority if (up_n > believed_w) begin
      tgt_hyst = up_n;
    end else if (down_n < believed_w) begin
      tgt_hyst = down_n;
    end else begin
      tgt_hyst = believed_w;
    end

    priority if (tgt_hyst > max_w) begin
      tgt = max_w;
    end else if (tgt_hyst < min_w) begin
      tgt = min_w;
    end else begin
      tgt = tgt_hyst;
    end
    if (tgt < LVL_W'(1)) begin
      tgt = LVL_W'(1);
    end
    if (tgt > LVL_W'(CORE_COUNT)) begin
      tgt = LVL_W'(CORE_COUNT);
    end
  end

  assign pick.sum    = sum_new;
  assign pick.target = tgt[CNT_W-1:0];

endmodule

// ===== hdl/core_count_hotplug_governor_top.sv =====
// Top level of the core-count hotplug governor: event register, governor state,
// result register. Depends on ccg_pkg, ccg_ifs, ccg_pick and assert_macros.svh.
//
// Usage:
//   events  - valid/ready beats carrying func (tick, suspend, resume), a load
//             sample and the mask of cores actually online.
//   results - one beat per event: up/down masks, desired count, believed online
//             count and the pending re-verify flag.
//   cfg     - register writes (enable, min/max core count, verify delay); cfg.ready
//             is always high. Write only while no event is in flight.
// Data path: an event beat taken into the event register goes through the governor
// update into the result register once that register is free to load.
// Throughput: one event per cycle while the result sink takes every beat; the moving
// sum, average and clamp are one pass of logic between the two registers.
// Reset clears the load history, moving sum and all governor state and loads
// the register defaults; no clearing sweep follows.
// When the result sink stalls, the result register holds, one more event is
// held in the event register, and then events.ready drops.
`include "assert_macros.svh"

module core_count_hotplug_governor_top import ccg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ccg_event_if.sink    events,
  ccg_result_if.source results,
  ccg_cfg_if.sink      cfg
);

  // configuration
  logic               gov_enable;
  logic [CNT_W-1:0]   core_floor;
  logic [CNT_W-1:0]   core_ceiling;
  logic [DELAY_W-1:0] verify_delay;

  // event register
  logic                  in_valid;
  func_t                 in_func;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [CORE_COUNT-1:0] in_online;

  // governor state
  logic [SAMPLE_W-1:0] history [HISTORY_DEPTH];
  logic [SUM_W-1:0]    load_sum;
  logic [SUM_W-1:0]    load_sum_next;
  logic [IDX_W-1:0]    hist_idx;
  logic [IDX_W-1:0]    hist_idx_next;
  logic [CNT_W-1:0]    believed;
  logic [CNT_W-1:0]    believed_next;
  logic                verify_flag;
  logic                verify_flag_next;
  logic [DELAY_W-1:0]  verify_count;
  logic [DELAY_W-1:0]  verify_count_next;
  logic                hist_we;
  logic                hist_fill;

  // result register
  logic                  res_valid;
  logic [CORE_COUNT-1:0] res_up;
  logic [CORE_COUNT-1:0] res_down;
  logic [CNT_W-1:0]      res_desired;
  logic [CORE_COUNT-1:0] up_calc;
  logic [CORE_COUNT-1:0] down_calc;
  logic [CNT_W-1:0]      desired_calc;

  logic               advance;
  logic [DELAY_W-1:0] count_dec;
  pick_t              pick;
  masks_t             mv;
  masks_t             fa;

  // Re-verify: every core below d must be online, every other core offline.
  function automatic masks_t force_masks(logic [CNT_W-1:0] d,
                                         logic [CORE_COUNT-1:0] online);
    masks_t           r;
    logic [CNT_W-1:0] cn;
    r = '0;
    for (int c = 0; c < CORE_COUNT; c++) begin
      cn = CNT_W'(c);
      if (cn < d && !online[c]) begin
        r.up[c] = 1'b1;
      end else if (cn >= d && online[c]) begin
        r.down[c] = 1'b1;
      end
    end
    return r;
  endfunction

  // Move from n to d cores, scanning from the top core; the first core found
  // in the wrong state stops the scan and keeps only the actions above it.
  function automatic masks_t move_masks(logic [CNT_W-1:0] n, logic [CNT_W-1:0] d,
                                        logic [CORE_COUNT-1:0] online);
    masks_t           r;
    logic [CNT_W-1:0] cn;
    logic             bad;
    r = '0;
    for (int c = CORE_COUNT - 1; c >= 0; c--) begin
      cn  = CNT_W'(c);
      bad = (cn < n && !online[c]) || (cn >= n && online[c]);
      if (bad) begin
        r.fault = 1'b1;
      end
      if (!r.fault) begin
        if (cn >= n && cn < d) begin
          r.up[c] = 1'b1;
        end else if (cn >= d && cn < n) begin
          r.down[c] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign advance      = in_valid && (!res_valid || results.ready);
  assign events.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gov_enable   <= 1'b1;
      core_floor   <= CNT_W'(1);
      core_ceiling <= CNT_W'(CORE_COUNT);
      verify_delay <= DELAY_W'(DELAY_RESET);
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_ENABLE:       gov_enable   <= cfg.data[0];
        CFG_CORE_FLOOR:   core_floor   <= cfg.data[CNT_W-1:0];
        CFG_CORE_CEILING: core_ceiling <= cfg.data[CNT_W-1:0];
        CFG_VERIFY_DELAY: verify_delay <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      in_func   <= func_t'(events.func);
      in_sample <= events.load_sample;
      in_online <= events.online_mask;
    end
  end

  ccg_pick u_pick (
    .load_sum     (load_sum),
    .old_entry    (history[hist_idx]),
    .sample       (in_sample),
    .believed     (believed),
    .core_floor   (core_floor),
    .core_ceiling (core_ceiling),
    .pick         (pick)
  );

  assign count_dec = verify_count - DELAY_W'(1);
  assign fa        = (in_func == FUNC_SUSPEND) ? force_masks(CNT_W'(1), in_online)
                                               : force_masks(pick.target, in_online);
  assign mv        = move_masks(believed, pick.target, in_online);

  always_comb begin
    load_sum_next     = load_sum;
    hist_idx_next     = hist_idx;
    believed_next     = believed;
    verify_flag_next  = verify_flag;
    verify_count_next = verify_count;
    hist_we           = 1'b0;
    hist_fill         = 1'b0;
    up_calc           = '0;
    down_calc         = '0;
    desired_calc      = '0;

    unique case (in_func)
      FUNC_TICK: begin
        if (gov_enable) begin
          hist_we       = 1'b1;
          load_sum_next = pick.sum;
          hist_idx_next = (hist_idx == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : hist_idx + IDX_W'(1);
          desired_calc  = pick.target;
          if (verify_flag) begin
            verify_count_next = count_dec;
            if (count_dec == '0) begin
              up_calc          = fa.up;
              down_calc        = fa.down;
              believed_next    = pick.target;
              verify_flag_next = 1'b0;
            end
          end else if (pick.target != believed) begin
            up_calc   = mv.up;
            down_calc = mv.down;
            if (mv.fault) begin
              verify_flag_next  = 1'b1;
              verify_count_next = (verify_delay == '0) ? DELAY_W'(1) : verify_delay;
            end else begin
              believed_next = pick.target;
            end
          end
        end
      end
      FUNC_SUSPEND: begin
        desired_calc  = CNT_W'(1);
        up_calc       = fa.up;
        down_calc     = fa.down;
        believed_next = CNT_W'(1);
      end
      FUNC_RESUME: begin
        hist_fill         = 1'b1;
        load_sum_next     = SUM_W'(SEED_SUM);
        verify_flag_next  = 1'b1;
        verify_count_next = DELAY_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
      load_sum     <= '0;
      hist_idx     <= '0;
      believed     <= '0;
      verify_flag  <= 1'b0;
      verify_count <= '0;
    end else if (advance) begin
      if (hist_fill) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          history[i] <= SAMPLE_W'(SEED);
        end
      end else if (hist_we) begin
        history[hist_idx] <= in_sample;
      end
      load_sum     <= load_sum_next;
      hist_idx     <= hist_idx_next;
      believed     <= believed_next;
      verify_flag  <= verify_flag_next;
      verify_count <= verify_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_up      <= up_calc;
      res_down    <= down_calc;
      res_desired <= desired_calc;
    end
  end

  // online count and pending flag read straight from the state, which only
  // moves together with the result register
  assign results.valid           = res_valid;
  assign results.cores_up_mask   = res_up;
  assign results.cores_down_mask = res_down;
  assign results.desired_cores   = res_desired;
  assign results.online_count    = believed;
  assign results.verify_pending  = verify_flag;

  `CCG_ASSERT(a_believed_range, believed <= CNT_W'(CORE_COUNT), "believed count too high")
  `CCG_ASSERT(a_idx_range, hist_idx <= IDX_W'(HISTORY_DEPTH - 1), "history index out of range")
  `CCG_ASSERT_IMPL(a_flag_count, verify_flag, verify_count != '0, "pending with zero count")
  `CCG_ASSERT_IMPL(a_masks_disjoint, res_valid, (res_up & res_down) == '0, "up and down both set")

endmodule

// ===== bench/tb_core_count_hotplug_governor_top.sv =====
// Testbench for core_count_hotplug_governor_top: directed table, then randomized phases.
// A local model of the governor predicts every result beat.
// Depends on ccg_pkg, ccg_ifs and core_count_hotplug_governor_top.
module tb_core_count_hotplug_governor_top;
  import ccg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned LOAD_ONE  = 1 << FRACTION_BITS;
  localparam int unsigned LOAD_HALF = LOAD_ONE / 2;
  localparam int unsigned SEED_RAW  = (2 << FRACTION_BITS) - 1;
  localparam int unsigned RESUME_SEED = (SEED_RAW > 16'hFFFF) ? 16'hFFFF : SEED_RAW;

  typedef struct packed {
    logic [CORE_COUNT-1:0] up;
    logic [CORE_COUNT-1:0] down;
    logic [CNT_W-1:0]      desired;
    logic [CNT_W-1:0]      online;
    logic                  verify;
  } plug_result_t;

  typedef enum bit {ROW_EVENT, ROW_CFG} row_kind_t;

  // code is func for events, register index for writes; value is sample or data
  typedef struct {
    row_kind_t             kind;
    logic [1:0]            code;
    logic [DELAY_W-1:0]    value;
    logic [CORE_COUNT-1:0] mask;
    bit                    has_want;
    plug_result_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ccg_event_if  ev_ch();
  ccg_result_if res_ch();
  ccg_cfg_if    cfg_ch();

  core_count_hotplug_governor_top dut (
    .clk(clk),
    .rst(rst),
    .events(ev_ch),
    .results(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadows
  logic                 reg_enable;
  logic [CNT_W-1:0]     reg_min;
  logic [CNT_W-1:0]     reg_max;
  logic [DELAY_W-1:0]   reg_delay;

  // governor state
  logic [SAMPLE_W-1:0]  gov_history [HISTORY_DEPTH];
  logic [SUM_W-1:0]     gov_sum;
  int unsigned          gov_idx;
  int unsigned          gov_online;
  logic                 gov_verify;
  logic [DELAY_W-1:0]   gov_countdown;

  plug_result_t          plug_expected [$];
  logic [CORE_COUNT-1:0] cores_online_sim;
  int                    load_level;
  int                    accepted_beats;
  int                    mismatch_count;
  bit                    quiet_sender;
  bit                    hold_active;
  bit                    held_off;

  stim_row_t directed_rows [27] = '{
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0000, 1'b1, '{4'b0001, 4'b0000, 3'd1, 3'd1, 1'b0}},
    '{ROW_EVENT, FUNC_SUSPEND, 20'h0,    4'b1111, 1'b1, '{4'b0000, 4'b1110, 3'd1, 3'd1, 1'b0}},
    '{ROW_EVENT, FUNC_RESUME,  20'h0,    4'b0000, 1'b1, '{4'b0000, 4'b0000, 3'd0, 3'd1, 1'b1}},
    '{ROW_EVENT, FUNC_UNUSED,  20'hFFFF, 4'b1010, 1'b1, '{4'b0000, 4'b0000, 3'd0, 3'd1, 1'b1}},
    '{ROW_EVENT, FUNC_TICK,    20'hFFFF, 4'b0001, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'hFFFF, 4'b1111, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_CEILING, 20'd2, 4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b1111, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_FLOOR, 20'd4,  4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_CEILING, 20'd4, 4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0011, 1'b0, '0},
    '{ROW_CFG,   CFG_VERIFY_DELAY, 20'd0, 4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_FLOOR, 20'd1,  4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_CEILING, 20'd1, 4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0101, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0101, 1'b0, '0},
    '{ROW_CFG,   CFG_ENABLE,   20'd0,    4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'hFFFF, 4'b1111, 1'b0, '0},
    '{ROW_EVENT, FUNC_SUSPEND, 20'h0,    4'b1110, 1'b0, '0},
    '{ROW_EVENT, FUNC_RESUME,  20'h0,    4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_ENABLE,   20'd1,    4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_CORE_CEILING, 20'd4, 4'b0000, 1'b0, '0},
    '{ROW_CFG,   CFG_VERIFY_DELAY, 20'd3, 4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'hAAAA, 4'b1111, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h5555, 4'b0000, 1'b0, '0},
    '{ROW_EVENT, FUNC_TICK,    20'h0,    4'b0001, 1'b0, '0}
  };

  // moving sum update and clamped target with half-core hysteresis
  function automatic int unsigned next_target(input logic [SAMPLE_W-1:0] sample);
    int unsigned avg, up_n, down_n, tgt;
    gov_sum = gov_sum - SUM_W'(gov_history[gov_idx]) + SUM_W'(sample);
    gov_history[gov_idx] = sample;
    gov_idx = (gov_idx == HISTORY_DEPTH - 1) ? 0 : gov_idx + 1;
    avg = gov_sum / HISTORY_DEPTH;
    up_n = (avg > LOAD_HALF) ? (avg - LOAD_HALF) >> FRACTION_BITS : 1;
    down_n = (avg + LOAD_HALF) >> FRACTION_BITS;
    if (up_n > gov_online) tgt = up_n;
    else if (down_n < gov_online) tgt = down_n;
    else tgt = gov_online;
    if (tgt > reg_max) tgt = reg_max;
    else if (tgt < reg_min) tgt = reg_min;
    if (tgt < 1) tgt = 1;
    if (tgt > CORE_COUNT) tgt = CORE_COUNT;
    return tgt;
  endfunction

  // re-verify: every core is driven to match the target
  function automatic void force_cores(input int unsigned d, input logic [CORE_COUNT-1:0] mask,
                                      inout plug_result_t r);
    int c;
    for (c = 0; c < CORE_COUNT; c++) begin
      if (c < d && !mask[c]) r.up[c] = 1'b1;
      else if (c >= d && mask[c]) r.down[c] = 1'b1;
    end
    gov_online = d;
  endfunction

  function automatic plug_result_t predict_hotplug(input logic [FUNC_W-1:0] fn,
                                                   input logic [SAMPLE_W-1:0] sample,
                                                   input logic [CORE_COUNT-1:0] mask);
    plug_result_t r;
    int unsigned tgt, n;
    int c;
    bit fault;
    r = '0;
    case (fn)
      FUNC_TICK: begin
        if (reg_enable) begin
          tgt = next_target(sample);
          r.desired = tgt[CNT_W-1:0];
          if (gov_verify) begin
            gov_countdown = gov_countdown - DELAY_W'(1);
            if (gov_countdown == '0) begin
              force_cores(tgt, mask, r);
              gov_verify = 1'b0;
            end
          end else if (tgt != gov_online) begin
            n = gov_online;
            fault = 1'b0;
            // scan from the top core; stop at the first core in the wrong state
            for (c = CORE_COUNT - 1; c >= 0; c--) begin
              if (!fault) begin
                if ((c < n && !mask[c]) || (c >= n && mask[c])) begin
                  fault = 1'b1;
                  gov_verify = 1'b1;
                  gov_countdown = (reg_delay == '0) ? DELAY_W'(1) : reg_delay;
                end else if (c >= n && c < tgt) begin
                  r.up[c] = 1'b1;
                end else if (c >= tgt && c < n) begin
                  r.down[c] = 1'b1;
                end
              end
            end
            if (!fault) gov_online = tgt;
          end
        end
      end
      FUNC_SUSPEND: begin
        r.desired = CNT_W'(1);
        force_cores(1, mask, r);
      end
      FUNC_RESUME: begin
        for (c = 0; c < HISTORY_DEPTH; c++) gov_history[c] = SAMPLE_W'(RESUME_SEED);
        gov_sum = SUM_W'(RESUME_SEED * HISTORY_DEPTH);
        gov_verify = 1'b1;
        gov_countdown = DELAY_W'(1);
      end
      default: ;
    endcase
    r.online = gov_online[CNT_W-1:0];
    r.verify = gov_verify;
    return r;
  endfunction

  // mostly back-to-back or short, now and then long
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called and returns at a falling edge
  task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [SAMPLE_W-1:0] sample,
                            input logic [CORE_COUNT-1:0] mask, input bit has_want,
                            input plug_result_t want);
    int gap;
    plug_result_t pred;
    gap = (quiet_sender || hold_active) ? 0 : idle_gap();
    repeat (gap) begin
      ev_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ev_ch.valid       <= 1'b1;
    ev_ch.func        <= fn;
    ev_ch.load_sample <= sample;
    ev_ch.online_mask <= mask;
    do @(posedge clk); while (!ev_ch.ready);
    pred = predict_hotplug(fn, sample, mask);
    plug_expected.push_back(has_want ? want : pred);
    // cores follow the issued masks
    cores_online_sim = (cores_online_sim | pred.up) & ~pred.down;
    accepted_beats++;
    @(negedge clk);
  endtask

  // register write, only once every result beat is back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
    ev_ch.valid <= 1'b0;
    while (plug_expected.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ENABLE:       reg_enable = data[0];
      CFG_CORE_FLOOR:   reg_min = data[CNT_W-1:0];
      CFG_CORE_CEILING: reg_max = data[CNT_W-1:0];
      CFG_VERIFY_DELAY: reg_delay = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input bit en, input int mn, input int mx, input int delay,
                           input int beats, input bit quiet);
    logic [FUNC_W-1:0]     fn;
    logic [SAMPLE_W-1:0]   sample;
    logic [CORE_COUNT-1:0] mask;
    int                    pick;
    write_reg(CFG_ENABLE, DELAY_W'(en));
    write_reg(CFG_CORE_FLOOR, DELAY_W'(mn));
    write_reg(CFG_CORE_CEILING, DELAY_W'(mx));
    write_reg(CFG_VERIFY_DELAY, DELAY_W'(delay));
    quiet_sender = quiet;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) fn = FUNC_SUSPEND;
      else if (pick < 6) fn = FUNC_RESUME;
      else if (pick < 8) fn = FUNC_UNUSED;
      else fn = FUNC_TICK;
      // load drifts between levels so the average crosses core thresholds
      if ($urandom_range(0, 11) == 0) load_level = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) sample = SAMPLE_W'($urandom);
      else sample = SAMPLE_W'(load_level * LOAD_ONE + $urandom_range(0, LOAD_ONE - 1));
      pick = $urandom_range(0, 99);
      if (pick < 80) mask = cores_online_sim;
      else if (pick < 92) mask = cores_online_sim ^ (4'b0001 << $urandom_range(0, 3));
      else mask = CORE_COUNT'($urandom);
      send_event(fn, sample, mask, 1'b0, '0);
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    int i;
    rst = 1'b1;
    ev_ch.valid = 1'b0;
    ev_ch.func = FUNC_TICK;
    ev_ch.load_sample = '0;
    ev_ch.online_mask = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ENABLE;
    cfg_ch.data = '0;
    reg_enable = 1'b1;
    reg_min = CNT_W'(1);
    reg_max = CNT_W'(CORE_COUNT);
    reg_delay = DELAY_W'(DELAY_RESET);
    for (i = 0; i < HISTORY_DEPTH; i++) gov_history[i] = '0;
    gov_sum = '0;
    gov_idx = 0;
    gov_online = 0;
    gov_verify = 1'b0;
    gov_countdown = '0;
    cores_online_sim = '0;
    load_level = 1;
    accepted_beats = 0;
    mismatch_count = 0;
    quiet_sender = 1'b0;
    hold_active = 1'b0;
    held_off = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].code, directed_rows[i].value);
      else
        send_event(directed_rows[i].code, directed_rows[i].value[SAMPLE_W-1:0],
                   directed_rows[i].mask, directed_rows[i].has_want, directed_rows[i].want);
    end

    run_phase(1'b1, 1, 4, 2, 215, 1'b0);
    run_phase(1'b1, 4, 4, 1, 215, 1'b1);
    run_phase(1'b1, 1, 1, 0, 215, 1'b0);
    run_phase(1'b0, 2, 3, 3, 50, 1'b0);
    run_phase(1'b1, 2, 3, $urandom_range(1, 6), 215, 1'b0);
    run_phase(1'b1, 1, 4, 1000000, 215, 1'b0);
    run_phase(1'b1, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 8),
              215, 1'b0);
    run_phase(1'b1, 1, 4, 1, 215, 1'b1);
    run_phase(1'b1, 3, 2, 2, 215, 1'b0);

    ev_ch.valid <= 1'b0;
    while (plug_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // result sink: random ready, plus one long hold-off to back up the event side
  initial begin
    int n;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && accepted_beats >= 300) begin
        held_off = 1'b1;
        hold_active = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (250) @(negedge clk);
        hold_active = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = idle_gap();
        if (n == 0) n = 1;
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    plug_result_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.cores_up_mask, res_ch.cores_down_mask, res_ch.desired_cores,
              res_ch.online_count, res_ch.verify_pending};
      if (plug_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: result beat with none expected: ", $time,
                   "up=%b down=%b desired=%0d online=%0d verify=%b",
                   got.up, got.down, got.desired, got.online, got.verify);
      end else begin
        want = plug_expected.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display("%0t: mismatch: ", $time,
                     "expected up=%b down=%b desired=%0d online=%0d verify=%b, ",
                     want.up, want.down, want.desired, want.online, want.verify,
                     "actual up=%b down=%b desired=%0d online=%0d verify=%b",
                     got.up, got.down, got.desired, got.online, got.verify);
        end
      end
    end
  end

  // watchdog
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ccg_pkg.sv
hdl/ccg_ifs.sv
hdl/ccg_pick.sv
hdl/core_count_hotplug_governor_top.sv
bench/tb_core_count_hotplug_governor_top.sv
